>>> src/rph_pkg.sv
// ----------------------------------------------------------------------------
// rph_pkg
// Shared types and constants for the password hiding block.
// ----------------------------------------------------------------------------
`default_nettype none

package rph_pkg;

  localparam int MAX_BLOCKS_DEF       = 8;
  localparam int MAX_SECRET_BYTES_DEF = 32;
  localparam int SECRET_HARD_LIMIT    = 39;
  localparam int CFG_ADDR_W           = 6;

  // register indexes
  localparam logic [2:0] REG_SECRET0 = 3'd0;
  localparam logic [2:0] REG_SECRET1 = 3'd1;
  localparam logic [2:0] REG_SECRET2 = 3'd2;
  localparam logic [2:0] REG_SECRET3 = 3'd3;
  localparam logic [2:0] REG_SECLEN  = 3'd4;

  // status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  typedef struct packed {
    logic [63:0] vector_high;
    logic [63:0] vector_low;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        first_block;
    logic        last_block;
  } in_word_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic        final_flag;
    logic        status;
  } out_word_t;

  // per-round additive constants
  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
        6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
        6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  // per-round rotate amounts
  function automatic logic [4:0] md5_s(input logic [5:0] i);
    logic [4:0] s;
    begin
      case ({i[5:4], i[1:0]})
        4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
        4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
        4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15;
        default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

endpackage

`default_nettype wire

>>> src/rph_stream_if.sv
// ----------------------------------------------------------------------------
// rph_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rph_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/rph_md5_core.sv
// ----------------------------------------------------------------------------
// rph_md5_core
// One-block MD5 compression, one round per cycle on a shared round unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rph_md5_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [511:0] msg,
  output logic              done,
  output logic [127:0]      digest
);
  import rph_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ROUND, S_DONE} state_t;

  state_t       state;
  logic [5:0]   rnd;
  logic [31:0]  a, b, c, d;
  logic [511:0] blk;
  logic [31:0]  f, mw, sum, rot, bn;
  logic [3:0]   g;
  logic [4:0]   sh;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;

  // round function and message word select
  always_comb begin
    case (rnd[5:4])
      2'd0: begin f = (b & c) | (~b & d); g = rnd[3:0]; end
      2'd1: begin f = (d & b) | (~d & c); g = 4'(5 * rnd + 1); end
      2'd2: begin f = b ^ c ^ d;          g = 4'(3 * rnd + 5); end
      default: begin f = c ^ (b | ~d);    g = 4'(7 * rnd); end
    endcase
    mw  = blk[32*g +: 32];
    sum = a + f + md5_k(rnd) + mw;
    sh  = md5_s(rnd);
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    bn  = b + rot;
  end

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      rnd   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            blk   <= msg;
            a     <= H0;
            b     <= H1;
            c     <= H2;
            d     <= H3;
            rnd   <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          a   <= d;
          d   <= c;
          c   <= b;
          b   <= bn;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          digest <= {a + H0, b + H1, c + H2, d + H3};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

`default_nettype wire

>>> src/radius_password_hide_top.sv
// ----------------------------------------------------------------------------
// radius_password_hide_top
// RADIUS User-Password hiding, one 16-byte block per input word.
// ----------------------------------------------------------------------------
// Usage: load the shared secret and its length over the APB port while idle,
// then push blocks on the in channel. Each block is XORed with
// MD5(secret || chain); the chain is the authenticator on a first block and
// the previous output after that. One word comes out per word in.
// A hashed block passes a load step, 64 rounds of the shared MD5 round unit,
// the digest add and the result register; an overflow block (past the
// MAX_BLOCKS-th) skips the hash and goes straight to the result register.
// One block is in flight at a time, on the single round unit; the next block
// needs the previous output as its chain.
// Reset clears the secret, the chain and the block count. If the receiver
// stalls, the result is held on out until taken; no new word is accepted
// until then.
// ----------------------------------------------------------------------------
`default_nettype none

module radius_password_hide_top #(
  parameter int MAX_BLOCKS       = rph_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_SECRET_BYTES = rph_pkg::MAX_SECRET_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  rph_stream_if.sink                          in_ch,
  rph_stream_if.source                        out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rph_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [63:0]                    pwdata,
  output logic      [63:0]                    prdata,
  output logic                                pready
);
  import rph_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int LIM_A  = (MAX_SECRET_BYTES < SECRET_HARD_LIMIT) ?
                          MAX_SECRET_BYTES : SECRET_HARD_LIMIT;

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_OUT} state_t;

  logic [255:0]     secret;
  logic [5:0]       secret_length;
  logic [63:0]      chain0, chain1;
  logic [CNT_W-1:0] block_count;
  state_t           state;
  in_word_t         cur;
  out_word_t        res;
  logic             out_valid;
  logic             start;
  logic [511:0]     msg;
  logic             hash_done;
  logic [127:0]     digest;
  logic [2:0]       reg_idx;
  logic             wr;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      secret        <= '0;
      secret_length <= '0;
    end else if (wr) begin
      case (reg_idx)
        REG_SECRET0: secret[255:192] <= pwdata;
        REG_SECRET1: secret[191:128] <= pwdata;
        REG_SECRET2: secret[127:64]  <= pwdata;
        REG_SECRET3: secret[63:0]    <= pwdata;
        REG_SECLEN:  secret_length   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SECRET0: prdata = secret[255:192];
      REG_SECRET1: prdata = secret[191:128];
      REG_SECRET2: prdata = secret[127:64];
      REG_SECRET3: prdata = secret[63:0];
      REG_SECLEN:  prdata = {58'd0, secret_length};
      default:     prdata = '0;
    endcase
  end

  // message block: secret bytes, chain, pad byte, bit length (little-endian)
  logic [5:0]  len;
  logic [5:0]  mlen;
  logic [7:0]  mbyte [64];
  logic [63:0] bits;
  logic [127:0] chain;
  assign len   = (secret_length > 6'(LIM_A)) ? 6'(LIM_A) : secret_length;
  assign mlen  = len + 6'd16;
  assign bits  = {55'd0, mlen, 3'd0};
  assign chain = {chain0, chain1};

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      if (i < 56 && 6'(i) < len) begin
        mbyte[i] = (i < 32) ? secret[255 - 8*(i % 32) -: 8] : 8'h00;
      end else if (i < 56 && 6'(i) < mlen) begin
        mbyte[i] = chain[127 - 8*((i - int'(len)) & 15) -: 8];
      end else if (i < 56 && 6'(i) == mlen) begin
        mbyte[i] = 8'h80;
      end else if (i >= 56) begin
        mbyte[i] = bits[8*(i-56) +: 8];
      end else begin
        mbyte[i] = 8'h00;
      end
    end
    for (int i = 0; i < 64; i++) begin
      msg[8*i +: 8] = mbyte[i];
    end
  end

  rph_md5_core u_md5 (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .msg    (msg),
    .done   (hash_done),
    .digest (digest)
  );

  // digest bytes in order: word0 low byte first
  logic [127:0] pad;
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      pad[127 - 8*i -: 8] = digest[96 - 32*(i/4) + 8*(i%4) +: 8];
    end
  end

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = res;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      start       <= 1'b0;
      chain0      <= '0;
      chain1      <= '0;
      block_count <= '0;
    end else begin
      start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cur <= in_ch.data;
            if (in_ch.data.first_block) begin
              chain0      <= in_ch.data.vector_high;
              chain1      <= in_ch.data.vector_low;
              block_count <= '0;
            end
            if (!in_ch.data.first_block && block_count >= CNT_W'(MAX_BLOCKS)) begin
              res.cipher_high <= in_ch.data.block_high;
              res.cipher_low  <= in_ch.data.block_low;
              res.final_flag  <= in_ch.data.last_block;
              res.status      <= STATUS_OVERFLOW;
              out_valid       <= 1'b1;
              state           <= S_OUT;
            end else begin
              start <= 1'b1;
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            res.cipher_high <= cur.block_high ^ pad[127:64];
            res.cipher_low  <= cur.block_low ^ pad[63:0];
            res.final_flag  <= cur.last_block;
            res.status      <= STATUS_OK;
            chain0          <= cur.block_high ^ pad[127:64];
            chain1          <= cur.block_low ^ pad[63:0];
            block_count     <= block_count + CNT_W'(1);
            out_valid       <= 1'b1;
            state           <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

`default_nettype wire
